/* hdl/edat_pkg.sv */
// ----------------------------------------------------------------------------
// edat_pkg: shared constants and types for the event dedup aging table
// Table geometry, command codes and the table control/read beat structs.
// ----------------------------------------------------------------------------
package edat_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int KEY_W     = 32;
    localparam int STAMP_W   = 32;
    localparam int HOLD_W    = 16;
    localparam int PURGE_W   = 5;

    localparam logic [HOLD_W-1:0]  HOLD_RESET = 16'd60;
    localparam logic [PURGE_W-1:0] PURGE_MAX  = 5'd31;

    // command codes
    localparam logic CMD_ALERT = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef struct packed {
        logic               rd_en;
        logic [IDX_W-1:0]   rd_addr;
        logic               wr_en;
        logic [IDX_W-1:0]   wr_addr;
        logic [KEY_W-1:0]   wr_key;
        logic [STAMP_W-1:0] wr_stamp;
        logic               clr_en;
        logic [IDX_W-1:0]   clr_addr;
    } t_tbl_ctl;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] stamp;
    } t_tbl_rd;

    typedef struct packed {
        logic zero;
        logic gt;
    } t_unit_res;

endpackage

/* hdl/event_dedup_aging_table.sv */
// ----------------------------------------------------------------------------
// event_dedup_aging_table: duplicate alert suppressor with aging
// Sequencer that walks the entry table through one shared compare unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: raise start with i_command/i_fingerprint; taken when busy
//   is low. Alert (command 0) looks up the fingerprint: a hit reports
//   duplicate, a miss is forwarded and cached in the lowest free entry
//   (table_full when none is free). Tick (command 1) bumps the seconds
//   counter, then erases entries older than the hold window.
//   Result beat: o_valid high for exactly one cycle with the flags and
//   o_purged_count. The receiver cannot stall; it must take the beat.
//   Walk: each entry is read and compared, one per cycle through the
//   single memory read port, behind the registered read stage; a finish
//   state then commits any new entry and reports. busy is high from the
//   accepting edge until the result is shown. A new start is taken in the
//   cycle the result is shown, so no new beat is taken before the last
//   one's result.
//   Config: i_cfg_we/i_cfg_data write hold_window; write only when idle.
//   Reset: valid bits cleared, seconds counter zero, hold window 60.
// ----------------------------------------------------------------------------
module event_dedup_aging_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [31:0] i_fingerprint,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic        o_forwarded,
    output logic        o_duplicate,
    output logic        o_table_full,
    output logic [4:0]  o_purged_count
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    localparam int IDX_W = edat_pkg::IDX_W;
    localparam int CNT_W = edat_pkg::CNT_W;

    logic [1:0]                    r_state;
    logic [edat_pkg::HOLD_W-1:0]   r_hold;
    logic [31:0]                   r_seconds;
    logic                          r_cmd;
    logic [31:0]                   r_fp;
    logic [CNT_W-1:0]              r_rd_cnt;
    logic                          r_ev_pend;
    logic [IDX_W-1:0]              r_ev_idx;
    logic                          r_dup;
    logic                          r_free_found;
    logic [IDX_W-1:0]              r_free_idx;
    logic [edat_pkg::PURGE_W-1:0]  r_purged;

    logic                          r_out_valid;
    logic                          r_out_fwd;
    logic                          r_out_dup;
    logic                          r_out_full;
    logic [edat_pkg::PURGE_W-1:0]  r_out_purged;

    edat_pkg::t_tbl_ctl  tbl_ctl;
    edat_pkg::t_tbl_rd   tbl_rd;
    edat_pkg::t_unit_res unit_res;
    logic [31:0]         unit_a;
    logic [31:0]         unit_b;
    logic                accept;
    logic                issue;
    logic                last_eval;
    logic                do_purge;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign issue     = (r_state == S_SCAN) && (r_rd_cnt < CNT_W'(edat_pkg::ENTRIES));
    assign last_eval = r_ev_pend && (r_ev_idx == IDX_W'(edat_pkg::ENTRIES - 1));

    // shared unit: key compare on alerts, age compare on ticks
    assign unit_a = (r_cmd == edat_pkg::CMD_TICK) ? r_seconds    : tbl_rd.key;
    assign unit_b = (r_cmd == edat_pkg::CMD_TICK) ? tbl_rd.stamp : r_fp;

    assign do_purge = (r_state == S_SCAN) && r_ev_pend && (r_cmd == edat_pkg::CMD_TICK)
                      && tbl_rd.valid && unit_res.gt;

    always_comb begin
        tbl_ctl          = '0;
        tbl_ctl.rd_en    = issue;
        tbl_ctl.rd_addr  = r_rd_cnt[IDX_W-1:0];
        tbl_ctl.clr_en   = do_purge;
        tbl_ctl.clr_addr = r_ev_idx;
        tbl_ctl.wr_en    = (r_state == S_FINISH) && (r_cmd == edat_pkg::CMD_ALERT)
                           && !r_dup && r_free_found;
        tbl_ctl.wr_addr  = r_free_idx;
        tbl_ctl.wr_key   = r_fp;
        tbl_ctl.wr_stamp = r_seconds;
    end

    edat_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (tbl_ctl),
        .o_rd    (tbl_rd)
    );

    edat_unit u_unit (
        .i_a    (unit_a),
        .i_b    (unit_b),
        .i_hold (r_hold),
        .o_res  (unit_res)
    );

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= edat_pkg::HOLD_RESET;
        end else if (i_cfg_we) begin
            r_hold <= i_cfg_data;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seconds   <= '0;
            r_rd_cnt    <= '0;
            r_ev_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state      <= S_SCAN;
                        r_cmd        <= i_command;
                        r_fp         <= i_fingerprint;
                        r_rd_cnt     <= '0;
                        r_ev_pend    <= 1'b0;
                        r_dup        <= 1'b0;
                        r_free_found <= 1'b0;
                        r_purged     <= '0;
                        if (i_command == edat_pkg::CMD_TICK) begin
                            r_seconds <= r_seconds + 32'd1;
                        end
                    end
                end
                S_SCAN: begin
                    // read pipe: entry issued this cycle is evaluated next cycle
                    if (issue) begin
                        r_rd_cnt <= r_rd_cnt + CNT_W'(1);
                        r_ev_idx <= r_rd_cnt[IDX_W-1:0];
                    end
                    r_ev_pend <= issue;
                    if (r_ev_pend && (r_cmd == edat_pkg::CMD_ALERT)) begin
                        if (tbl_rd.valid) begin
                            if (unit_res.zero) begin
                                r_dup <= 1'b1;
                            end
                        end else if (!r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_ev_idx;
                        end
                    end
                    if (do_purge && (r_purged != edat_pkg::PURGE_MAX)) begin
                        r_purged <= r_purged + edat_pkg::PURGE_W'(1);
                    end
                    if (last_eval) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b1;
                    if (r_cmd == edat_pkg::CMD_TICK) begin
                        r_out_fwd    <= 1'b0;
                        r_out_dup    <= 1'b0;
                        r_out_full   <= 1'b0;
                        r_out_purged <= r_purged;
                    end else begin
                        r_out_fwd    <= !r_dup;
                        r_out_dup    <= r_dup;
                        r_out_full   <= !r_dup && !r_free_found;
                        r_out_purged <= '0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_forwarded    = r_out_fwd;
    assign o_duplicate    = r_out_dup;
    assign o_table_full   = r_out_full;
    assign o_purged_count = r_out_purged;

`ifndef SYNTHESIS
    a_fwd_dup_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_forwarded && o_duplicate))
        else $error("forwarded and duplicate both set");

    a_full_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> o_forwarded)
        else $error("table_full without forwarded");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("not busy after accepted beat");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(r_state == S_FINISH)))
        else $error("result beat outside finish");
`endif

endmodule

/* hdl/edat_table.sv */
// ----------------------------------------------------------------------------
// edat_table: entry storage
// Key/stamp memory with registered read, plus per-entry valid flops.
// ----------------------------------------------------------------------------
module edat_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  edat_pkg::t_tbl_ctl i_ctl,
    output edat_pkg::t_tbl_rd  o_rd
);

    logic [edat_pkg::KEY_W-1:0]   mem_key   [edat_pkg::ENTRIES];
    logic [edat_pkg::STAMP_W-1:0] mem_stamp [edat_pkg::ENTRIES];
    logic [edat_pkg::ENTRIES-1:0] r_valid;
    edat_pkg::t_tbl_rd            r_rd;

    // valid bits: set on write, cleared on purge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_ctl.clr_en) begin
                r_valid[i_ctl.clr_addr] <= 1'b0;
            end
            if (i_ctl.wr_en) begin
                r_valid[i_ctl.wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem_key[i_ctl.wr_addr]   <= i_ctl.wr_key;
            mem_stamp[i_ctl.wr_addr] <= i_ctl.wr_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd.valid <= r_valid[i_ctl.rd_addr];
            r_rd.key   <= mem_key[i_ctl.rd_addr];
            r_rd.stamp <= mem_stamp[i_ctl.rd_addr];
        end
    end

    assign o_rd = r_rd;

endmodule

/* hdl/edat_unit.sv */
// ----------------------------------------------------------------------------
// edat_unit: shared subtract/compare unit
// One 32-bit subtractor; flags a zero difference (key match) and a
// difference above the hold window (entry aged out).
// ----------------------------------------------------------------------------
module edat_unit (
    input  logic [31:0]                i_a,
    input  logic [31:0]                i_b,
    input  logic [edat_pkg::HOLD_W-1:0] i_hold,
    output edat_pkg::t_unit_res        o_res
);

    logic [31:0] diff;

    assign diff       = i_a - i_b;
    assign o_res.zero = (diff == 32'd0);
    assign o_res.gt   = (diff > {{(32 - edat_pkg::HOLD_W){1'b0}}, i_hold});

endmodule

/* tb/dedup_tb_pkg.sv */
// ----------------------------------------------------------------------------
// dedup_tb_pkg: checking side of the event dedup aging table bench
// Table predictor and the in-order store of expected result beats.
// ----------------------------------------------------------------------------
package dedup_tb_pkg;

    import edat_pkg::*;

    typedef struct packed {
        logic               forwarded;
        logic               duplicate;
        logic               table_full;
        logic [PURGE_W-1:0] purged_count;
    } verdict_t;

    class dedup_scoreboard;

        // shadow of the block's table, counter and hold window
        bit                 live[ENTRIES];
        logic [KEY_W-1:0]   key_of[ENTRIES];
        logic [STAMP_W-1:0] stamp_of[ENTRIES];
        logic [STAMP_W-1:0] seconds_now;
        logic [HOLD_W-1:0]  hold_window;

        verdict_t           pending_verdicts[$];
        int                 errors;

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                live[i]     = 1'b0;
                key_of[i]   = '0;
                stamp_of[i] = '0;
            end
            seconds_now = '0;
            hold_window = HOLD_RESET;
            errors      = 0;
        endfunction

        function void set_hold(logic [HOLD_W-1:0] value);
            hold_window = value;
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction

        // Work out the verdict of one accepted beat and queue it.
        function void note_event(logic cmd, logic [KEY_W-1:0] fp);
            verdict_t           v;
            logic [STAMP_W-1:0] age;
            int                 purged;
            int                 free_slot;
            bit                 hit;
            v = '0;
            if (cmd == CMD_TICK) begin
                seconds_now = seconds_now + 1'b1;
                purged = 0;
                for (int i = 0; i < ENTRIES; i++) begin
                    age = seconds_now - stamp_of[i];
                    if (live[i] && age > STAMP_W'(hold_window)) begin
                        live[i] = 1'b0;
                        if (purged < int'(PURGE_MAX))
                            purged++;
                    end
                end
                v.purged_count = PURGE_W'(purged);
            end else begin
                free_slot = -1;
                hit = 1'b0;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (live[i]) begin
                        if (key_of[i] == fp)
                            hit = 1'b1;
                    end else if (free_slot < 0) begin
                        free_slot = i;
                    end
                end
                if (hit) begin
                    v.duplicate = 1'b1;
                end else begin
                    v.forwarded = 1'b1;
                    if (free_slot >= 0) begin
                        live[free_slot]     = 1'b1;
                        key_of[free_slot]   = fp;
                        stamp_of[free_slot] = seconds_now;
                    end else begin
                        v.table_full = 1'b1;
                    end
                end
            end
            pending_verdicts.push_back(v);
        endfunction

        // Compare one result beat with the oldest verdict.
        function void check_verdict(logic fwd, logic dup, logic full,
                                    logic [PURGE_W-1:0] purged);
            verdict_t want;
            if (pending_verdicts.size() == 0) begin
                $error("result beat with no alert or tick outstanding");
                errors++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (fwd !== want.forwarded) begin
                $error("forwarded: expected %0b, got %0b", want.forwarded, fwd);
                errors++;
            end
            if (dup !== want.duplicate) begin
                $error("duplicate: expected %0b, got %0b", want.duplicate, dup);
                errors++;
            end
            if (full !== want.table_full) begin
                $error("table_full: expected %0b, got %0b", want.table_full, full);
                errors++;
            end
            if (purged !== want.purged_count) begin
                $error("purged_count: expected %0d, got %0d", want.purged_count, purged);
                errors++;
            end
        endfunction

    endclass

endpackage

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the event dedup aging table
// Drives alert and tick beats through the start/busy handshake, predicts
// each result beat with a shadow table and checks every field in order.
// ----------------------------------------------------------------------------
module tb_top;

    import edat_pkg::*;
    import dedup_tb_pkg::*;

    localparam int POOL_SIZE   = 24;        // more keys than entries -> full table
    localparam int TICK_PCT    = 25;        // share of ticks in random traffic
    localparam int REUSE_PCT   = 55;        // alerts that reuse a pooled key
    localparam int MAX_GAP     = 24;        // longest sender idle, > one table walk
    localparam int DRAIN_WAIT  = 2 * ENTRIES + 8;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_command;
    logic [KEY_W-1:0]     i_fingerprint;
    logic                 i_cfg_we;
    logic [HOLD_W-1:0]    i_cfg_data;
    logic                 o_valid;
    logic                 o_forwarded;
    logic                 o_duplicate;
    logic                 o_table_full;
    logic [PURGE_W-1:0]   o_purged_count;

    dedup_scoreboard      sb;
    int                   idle_pct;
    logic [KEY_W-1:0]     key_pool[POOL_SIZE];

    event_dedup_aging_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_fingerprint  (i_fingerprint),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_forwarded    (o_forwarded),
        .o_duplicate    (o_duplicate),
        .o_table_full   (o_table_full),
        .o_purged_count (o_purged_count)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Hard stop. Slowest legal run is ~1925 beats, each a full table walk plus
    // the longest idle gap, about 0.8M time units; this allows several times that.
    initial begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

    // Result monitor: the receiver cannot stall, so every strobed cycle is
    // a beat and gets checked at the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1)
            sb.check_verdict(o_forwarded, o_duplicate, o_table_full, o_purged_count);
    end

    // Present one beat from a falling edge, optionally after a random idle
    // stretch, and hold it until an edge with busy low takes it. Returns on
    // the falling edge after acceptance with start still high, so a caller
    // with another beat ready keeps start up without a glitch.
    task automatic push_event(input logic cmd, input logic [KEY_W-1:0] fp);
        int gap;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, MAX_GAP);
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start         <= 1'b1;
        i_command     <= cmd;
        i_fingerprint <= fp;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_event(cmd, fp);
        @(negedge i_clk);
    endtask

    // Hold window write: only with nothing in flight and the block idle.
    // Every beat yields a result, so an empty queue means the walk is done.
    task automatic write_hold(input logic [HOLD_W-1:0] value);
        while (sb.pending() != 0 || busy !== 1'b0)
            @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.set_hold(value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Random traffic: mostly alerts, many reusing a pooled key so that
    // duplicates, a full table and purges of live keys all show up.
    // Fingerprints on ticks are random too; the block must ignore them.
    task automatic run_random(input int count);
        logic             cmd;
        logic [KEY_W-1:0] fp;
        for (int n = 0; n < count; n++) begin
            fp = $urandom;
            if ($urandom_range(99) < TICK_PCT) begin
                cmd = CMD_TICK;
            end else begin
                cmd = CMD_ALERT;
                if ($urandom_range(99) < REUSE_PCT)
                    fp = key_pool[$urandom_range(POOL_SIZE - 1)];
                else
                    key_pool[$urandom_range(POOL_SIZE - 1)] = fp;
            end
            push_event(cmd, fp);
        end
        start <= 1'b0;
    endtask

    initial begin
        sb             = new();
        idle_pct       = 11;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_command      = CMD_ALERT;
        i_fingerprint  = '0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed part ---
        // Reset hold window of 60: extreme keys, a duplicate, and a tick
        // that must not purge anything.
        push_event(CMD_ALERT, 32'h0000_0000);
        push_event(CMD_ALERT, 32'hFFFF_FFFF);
        push_event(CMD_ALERT, 32'h0000_0000);
        push_event(CMD_TICK,  32'h1234_5678);
        start <= 1'b0;

        // Zero hold: the next tick ages both entries out.
        write_hold(16'd0);
        push_event(CMD_TICK, 32'hFFFF_FFFF);
        // Fill every entry, overflow once (forwarded uncached), hit a cached
        // key, then one tick clears the whole table at once.
        for (int i = 0; i < ENTRIES; i++)
            push_event(CMD_ALERT, 32'hA5A5_0000 | i);
        push_event(CMD_ALERT, 32'h5A5A_FFFF);
        push_event(CMD_ALERT, 32'hA5A5_0003);
        push_event(CMD_TICK,  32'h0000_0000);
        // Freed table takes a new key again.
        push_event(CMD_ALERT, 32'h5A5A_FFFF);
        start <= 1'b0;

        // --- random part ---
        // Sender idles now and then; short window so purges are frequent.
        write_hold(16'd4);
        run_random(500);
        // Widest window: nothing ever ages out, table stays full.
        write_hold(16'hFFFF);
        run_random(150);
        // Sender idles most of the time.
        idle_pct = 81;
        write_hold(16'd1);
        run_random(600);
        // Back-to-back beats, start held high across results.
        idle_pct = 0;
        write_hold(16'd9);
        run_random(650);

        // Drain, then watch for stray beats for a while.
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
